[hdl/assert_macros.svh]
// Assertion helpers. Both sample on clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLY(lbl, pre, post)
`endif
`endif

[hdl/rti_pkg.sv]
`timescale 1ns / 1ps
package rti_pkg;

    localparam int FIELD_W    = 48;
    localparam int CW         = 16;             // one signed coordinate
    localparam int DW         = CW + 1;         // coordinate difference
    localparam int NW         = 2 * DW + 1;     // cross product term
    localparam int PW         = DW + NW + 2;    // dot product
    localparam int RATIO_FRAC = 16;             // Q16.16 ratios
    localparam int RN_W       = PW + 2 + RATIO_FRAC;
    localparam int PN_W       = PW + DW + 1;
    localparam int QW         = 32;             // quotient bits per divider
    localparam int QDEPTH     = 4;              // power of two
    localparam int QPTR_W     = $clog2(QDEPTH);

    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [NW-1:0] cross_t;
    typedef logic signed [PW-1:0] dot_t;

    typedef struct packed {
        logic                       hit;
        logic [PW-1:0]              den;
        logic signed [RN_W-1:0]     num_t;
        logic signed [RN_W-1:0]     num_a;
        logic signed [RN_W-1:0]     num_b;
        logic signed [RN_W-1:0]     num_c;
        logic [2:0][PN_W-1:0]       num_p;
        logic [2:0][CW-1:0]         base;
    } entry_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_status_t;

endpackage

[hdl/ray_triangle_intersect.sv]
`timescale 1ns / 1ps
// One-sided ray/triangle hit test with barycentrics and hit point, in exact
// fixed point. Each input beat carries a ray and a triangle (coordinates
// signed Q8.8, packed z:y:x) and yields exactly one result beat, in order.
// The block takes one beat per clock and keeps that rate as long as the
// result side does not stall. A beat passes through the front pipeline
// (edges, cross products, dot products, hit classification), a four-entry
// queue and the back dividers (an input register, then one quotient bit per
// stage, 32 bits, all seven quotients side by side); it then lands in the
// output register. in_stall rises only when the queue is full; a stalled
// result holds the back pipeline, so the queue then absorbs the front's
// work in flight.
// Quotients round toward minus infinity and saturate; on a miss every
// result field is zero.
module ray_triangle_intersect import rti_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [FIELD_W-1:0]   ray_origin,
    input  logic [FIELD_W-1:0]   ray_dir,
    input  logic [FIELD_W-1:0]   vert_a,
    input  logic [FIELD_W-1:0]   vert_b,
    input  logic [FIELD_W-1:0]   vert_c,
    input  logic                 plane_mode,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic [30:0]          dist_t,
    output logic signed [31:0]   bary_a,
    output logic signed [31:0]   bary_b,
    output logic signed [31:0]   bary_c,
    output logic signed [CW-1:0] hit_x,
    output logic signed [CW-1:0] hit_y,
    output logic signed [CW-1:0] hit_z
);

    logic       push, pop;
    entry_t     push_entry, head;
    q_status_t  q_status;

    // front: accept, compute the plane terms and decide hit or miss
    rti_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ray_origin (ray_origin),
        .ray_dir    (ray_dir),
        .vert_a     (vert_a),
        .vert_b     (vert_b),
        .vert_c     (vert_c),
        .plane_mode (plane_mode),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // queue: lets the front keep going for a few beats while the back holds
    rti_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // back: divide by d, saturate, zero the fields of a miss
    rti_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .dist_t     (dist_t),
        .bary_a     (bary_a),
        .bary_b     (bary_b),
        .bary_c     (bary_c),
        .hit_x      (hit_x),
        .hit_y      (hit_y),
        .hit_z      (hit_z)
    );

endmodule

[hdl/rti_front.sv]
`timescale 1ns / 1ps
module rti_front import rti_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FIELD_W-1:0]  ray_origin,
    input  logic [FIELD_W-1:0]  ray_dir,
    input  logic [FIELD_W-1:0]  vert_a,
    input  logic [FIELD_W-1:0]  vert_b,
    input  logic [FIELD_W-1:0]  vert_c,
    input  logic                plane_mode,
    input  q_status_t           q_status,
    output logic                push,
    output entry_t              push_entry
);

    function automatic logic signed [CW-1:0] coord(logic [FIELD_W-1:0] f, int k);
        return f[k*CW +: CW];
    endfunction

    function automatic cross_t xterm(diff_t a, diff_t b, diff_t c, diff_t d);
        return NW'(a) * NW'(b) - NW'(c) * NW'(d);
    endfunction

    function automatic dot_t dot3(diff_t x0, diff_t x1, diff_t x2,
                                  cross_t y0, cross_t y1, cross_t y2);
        return PW'(x0) * PW'(y0) + PW'(x1) * PW'(y1) + PW'(x2) * PW'(y2);
    endfunction

    logic en;

    // stage 1: differences
    logic                   s1_valid_reg;
    diff_t                  s1_ab_reg [3], s1_ac_reg [3], s1_qp_reg [3], s1_ap_reg [3];
    diff_t                  s1_ab_next [3], s1_ac_next [3], s1_qp_next [3], s1_ap_next [3];
    logic [2:0][CW-1:0]     s1_base_reg, s1_base_next;
    logic                   s1_plane_reg;

    // stage 2: normal and e
    logic                   s2_valid_reg;
    cross_t                 s2_n_reg [3], s2_e_reg [3], s2_n_next [3], s2_e_next [3];
    diff_t                  s2_ab_reg [3], s2_ac_reg [3], s2_qp_reg [3], s2_ap_reg [3];
    logic [2:0][CW-1:0]     s2_base_reg;
    logic                   s2_plane_reg;

    // stage 3: dot products
    logic                   s3_valid_reg;
    dot_t                   s3_d_reg, s3_t_reg, s3_v_reg, s3_wn_reg;
    dot_t                   s3_d_next, s3_t_next, s3_v_next, s3_wn_next;
    diff_t                  s3_ab_reg [3], s3_ac_reg [3];
    logic [2:0][CW-1:0]     s3_base_reg;
    logic                   s3_plane_reg;

    // stage 4: classify and form numerators
    logic                   s4_valid_reg;
    entry_t                 s4_entry_reg, s4_entry_next;
    dot_t                   w;
    logic signed [PW:0]     vw;

    assign en       = !q_status.full;
    assign in_stall = q_status.full;
    assign push     = s4_valid_reg && en;
    assign push_entry = s4_entry_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_ab_next[i]   = DW'(coord(vert_b, i)) - DW'(coord(vert_a, i));
            s1_ac_next[i]   = DW'(coord(vert_c, i)) - DW'(coord(vert_a, i));
            s1_qp_next[i]   = -DW'(coord(ray_dir, i));
            s1_ap_next[i]   = DW'(coord(ray_origin, i)) - DW'(coord(vert_a, i));
            s1_base_next[i] = coord(vert_a, i);
        end
    end

    always_comb
    begin
        s2_n_next[0] = xterm(s1_ab_reg[1], s1_ac_reg[2], s1_ab_reg[2], s1_ac_reg[1]);
        s2_n_next[1] = xterm(s1_ab_reg[2], s1_ac_reg[0], s1_ab_reg[0], s1_ac_reg[2]);
        s2_n_next[2] = xterm(s1_ab_reg[0], s1_ac_reg[1], s1_ab_reg[1], s1_ac_reg[0]);
        s2_e_next[0] = xterm(s1_qp_reg[1], s1_ap_reg[2], s1_qp_reg[2], s1_ap_reg[1]);
        s2_e_next[1] = xterm(s1_qp_reg[2], s1_ap_reg[0], s1_qp_reg[0], s1_ap_reg[2]);
        s2_e_next[2] = xterm(s1_qp_reg[0], s1_ap_reg[1], s1_qp_reg[1], s1_ap_reg[0]);
    end

    always_comb
    begin
        s3_d_next  = dot3(s2_qp_reg[0], s2_qp_reg[1], s2_qp_reg[2],
                          s2_n_reg[0], s2_n_reg[1], s2_n_reg[2]);
        s3_t_next  = dot3(s2_ap_reg[0], s2_ap_reg[1], s2_ap_reg[2],
                          s2_n_reg[0], s2_n_reg[1], s2_n_reg[2]);
        s3_v_next  = dot3(s2_ac_reg[0], s2_ac_reg[1], s2_ac_reg[2],
                          s2_e_reg[0], s2_e_reg[1], s2_e_reg[2]);
        s3_wn_next = dot3(s2_ab_reg[0], s2_ab_reg[1], s2_ab_reg[2],
                          s2_e_reg[0], s2_e_reg[1], s2_e_reg[2]);
    end

    always_comb
    begin
        w  = -s3_wn_reg;
        vw = (PW+1)'(s3_v_reg) + (PW+1)'(w);
        s4_entry_next.hit   = (s3_d_reg > 0) && (s3_t_reg >= 0) &&
                              (s3_plane_reg ||
                               ((s3_v_reg >= 0) && (s3_v_reg <= s3_d_reg) &&
                                (w >= 0) && (vw <= (PW+1)'(s3_d_reg))));
        s4_entry_next.den   = s3_d_reg;
        s4_entry_next.num_t = RN_W'(s3_t_reg) <<< RATIO_FRAC;
        s4_entry_next.num_a = (RN_W'(s3_d_reg) - RN_W'(s3_v_reg) - RN_W'(w)) <<< RATIO_FRAC;
        s4_entry_next.num_b = RN_W'(s3_v_reg) <<< RATIO_FRAC;
        s4_entry_next.num_c = RN_W'(w) <<< RATIO_FRAC;
        for (int i = 0; i < 3; i++)
        begin
            s4_entry_next.num_p[i] = PN_W'(s3_v_reg) * PN_W'(s3_ab_reg[i]) +
                                     PN_W'(w) * PN_W'(s3_ac_reg[i]);
        end
        s4_entry_next.base  = s3_base_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ab_reg    <= s1_ab_next;
            s1_ac_reg    <= s1_ac_next;
            s1_qp_reg    <= s1_qp_next;
            s1_ap_reg    <= s1_ap_next;
            s1_base_reg  <= s1_base_next;
            s1_plane_reg <= plane_mode;

            s2_n_reg     <= s2_n_next;
            s2_e_reg     <= s2_e_next;
            s2_ab_reg    <= s1_ab_reg;
            s2_ac_reg    <= s1_ac_reg;
            s2_qp_reg    <= s1_qp_reg;
            s2_ap_reg    <= s1_ap_reg;
            s2_base_reg  <= s1_base_reg;
            s2_plane_reg <= s1_plane_reg;

            s3_d_reg     <= s3_d_next;
            s3_t_reg     <= s3_t_next;
            s3_v_reg     <= s3_v_next;
            s3_wn_reg    <= s3_wn_next;
            s3_ab_reg    <= s2_ab_reg;
            s3_ac_reg    <= s2_ac_reg;
            s3_base_reg  <= s2_base_reg;
            s3_plane_reg <= s2_plane_reg;

            s4_entry_reg <= s4_entry_next;
        end
    end

endmodule

[hdl/rti_queue.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rti_queue import rti_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  entry_t      push_entry,
    input  logic        pop,
    output entry_t      head,
    output q_status_t   status
);

    entry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;

    assign head            = mem_reg[rd_ptr_reg];
    assign status.full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign status.nonempty = (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    `ASSERT_ALWAYS(a_push_not_full, !(push && status.full))
    `ASSERT_ALWAYS(a_pop_not_empty, !(pop && !status.nonempty))
    `ASSERT_ALWAYS(a_count_bound, count_reg <= (QPTR_W+1)'(QDEPTH))
    `ASSERT_IMPLY(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

[hdl/rti_div.sv]
`timescale 1ns / 1ps
module rti_div #(
    parameter int NUM_W = 72,
    parameter int DEN_W = 54,
    parameter int Q_W   = 32
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic [Q_W-1:0]          quo,
    output logic                    neg,
    output logic                    ovf
);

    localparam int MAG_W = NUM_W + 1;
    localparam int HI_W  = MAG_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic               neg0_reg;
    logic [MAG_W-1:0]   mag0_reg, mag_next;
    logic [DEN_W-1:0]   den0_reg;

    logic [DEN_W-1:0]   r_reg   [1:Q_W];
    logic [Q_W-1:0]     low_reg [1:Q_W];
    logic [Q_W-1:0]     q_reg   [1:Q_W];
    logic [DEN_W-1:0]   den_reg [1:Q_W];
    logic               neg_reg [1:Q_W];
    logic               ovf_reg [1:Q_W];

    // floor for negative numerators: divide |num| + den - 1
    always_comb
    begin
        if (num[NUM_W-1])
            mag_next = (-MAG_W'(num)) + MAG_W'(den) - 1'b1;
        else
            mag_next = MAG_W'(num);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg0_reg <= num[NUM_W-1];
            mag0_reg <= mag_next;
            den0_reg <= den;
        end
    end

    for (genvar k = 1; k <= Q_W; k++)
    begin : g_step
        logic [DEN_W-1:0]   r_in, d_in;
        logic [Q_W-1:0]     low_in, q_in;
        logic               neg_in, ovf_in;
        logic [DEN_W:0]     r2;
        logic               ge;

        if (k == 1)
        begin : g_first
            logic [CMP_W-1:0] hi_ext, den_ext;
            assign hi_ext  = CMP_W'(mag0_reg[MAG_W-1:Q_W]);
            assign den_ext = CMP_W'(den0_reg);
            assign r_in    = hi_ext[DEN_W-1:0];
            assign low_in  = mag0_reg[Q_W-1:0];
            assign q_in    = '0;
            assign d_in    = den0_reg;
            assign neg_in  = neg0_reg;
            assign ovf_in  = (hi_ext >= den_ext);
        end
        else
        begin : g_rest
            assign r_in   = r_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign d_in   = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
        end

        assign r2 = {r_in, low_in[Q_W-1]};
        assign ge = (r2 >= {1'b0, d_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]   <= ge ? DEN_W'(r2 - {1'b0, d_in}) : r2[DEN_W-1:0];
                low_reg[k] <= {low_in[Q_W-2:0], 1'b0};
                q_reg[k]   <= {q_in[Q_W-2:0], ge};
                den_reg[k] <= d_in;
                neg_reg[k] <= neg_in;
                ovf_reg[k] <= ovf_in;
            end
        end
    end

    assign quo = q_reg[Q_W];
    assign neg = neg_reg[Q_W];
    assign ovf = ovf_reg[Q_W];

endmodule

[hdl/rti_back.sv]
`timescale 1ns / 1ps
module rti_back import rti_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  q_status_t           q_status,
    input  entry_t              head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic [30:0]         dist_t,
    output logic signed [31:0]  bary_a,
    output logic signed [31:0]  bary_b,
    output logic signed [31:0]  bary_c,
    output logic signed [CW-1:0] hit_x,
    output logic signed [CW-1:0] hit_y,
    output logic signed [CW-1:0] hit_z
);

    localparam int LAT  = QW + 1;
    localparam int DL_W = QW + 2;
    localparam int PT_W = QW + 3;
    localparam logic signed [PT_W-1:0] P_MAX = PT_W'(2 ** (CW - 1) - 1);
    localparam logic signed [PT_W-1:0] P_MIN = -P_MAX - 1;

    function automatic logic [31:0] sat_ratio(logic [QW-1:0] q, logic n, logic o);
        logic [31:0] r;
        if (n)
            r = (o || (q > QW'(33'h080000000))) ? 32'h80000000 : 32'(-q);
        else
            r = (o || q[QW-1:31] != '0) ? 32'h7FFFFFFF : q[31:0];
        return r;
    endfunction

    function automatic logic [CW-1:0] sat_point(logic [QW-1:0] q, logic n, logic o,
                                                logic [CW-1:0] a);
        logic signed [DL_W-1:0] dq;
        logic signed [PT_W-1:0] p;
        if (o)
            dq = {2'b01, {QW{1'b0}}};
        else
            dq = DL_W'({1'b0, q});
        if (n)
            dq = -dq;
        p = PT_W'($signed(a)) + PT_W'(dq);
        if (p > P_MAX)
            p = P_MAX;
        else if (p < P_MIN)
            p = P_MIN;
        return p[CW-1:0];
    endfunction

    logic               en;
    logic [LAT-1:0]     tv_reg, th_reg;
    logic [2:0][CW-1:0] tb_reg [LAT];

    logic [QW-1:0]      q_t, q_a, q_b, q_c, q_x, q_y, q_z;
    logic               n_t, n_a, n_b, n_c, n_x, n_y, n_z;
    logic               o_t, o_a, o_b, o_c, o_x, o_y, o_z;

    logic               out_valid_reg, hit_reg;
    logic [30:0]        dist_reg;
    logic [31:0]        ba_reg, bb_reg, bc_reg;
    logic [CW-1:0]      px_reg, py_reg, pz_reg;

    // the whole back pipeline holds while a finished result waits
    assign en  = !(out_valid_reg && out_stall);
    assign pop = en && q_status.nonempty;

    rti_div #(.NUM_W(RN_W), .DEN_W(PW), .Q_W(QW)) u_div_t (
        .clk(clk), .en(en), .num(head.num_t), .den(head.den), .quo(q_t), .neg(n_t), .ovf(o_t));
    rti_div #(.NUM_W(RN_W), .DEN_W(PW), .Q_W(QW)) u_div_a (
        .clk(clk), .en(en), .num(head.num_a), .den(head.den), .quo(q_a), .neg(n_a), .ovf(o_a));
    rti_div #(.NUM_W(RN_W), .DEN_W(PW), .Q_W(QW)) u_div_b (
        .clk(clk), .en(en), .num(head.num_b), .den(head.den), .quo(q_b), .neg(n_b), .ovf(o_b));
    rti_div #(.NUM_W(RN_W), .DEN_W(PW), .Q_W(QW)) u_div_c (
        .clk(clk), .en(en), .num(head.num_c), .den(head.den), .quo(q_c), .neg(n_c), .ovf(o_c));
    rti_div #(.NUM_W(PN_W), .DEN_W(PW), .Q_W(QW)) u_div_x (
        .clk(clk), .en(en), .num($signed(head.num_p[0])), .den(head.den),
        .quo(q_x), .neg(n_x), .ovf(o_x));
    rti_div #(.NUM_W(PN_W), .DEN_W(PW), .Q_W(QW)) u_div_y (
        .clk(clk), .en(en), .num($signed(head.num_p[1])), .den(head.den),
        .quo(q_y), .neg(n_y), .ovf(o_y));
    rti_div #(.NUM_W(PN_W), .DEN_W(PW), .Q_W(QW)) u_div_z (
        .clk(clk), .en(en), .num($signed(head.num_p[2])), .den(head.den),
        .quo(q_z), .neg(n_z), .ovf(o_z));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tv_reg        <= {tv_reg[LAT-2:0], pop};
            out_valid_reg <= tv_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_reg    <= {th_reg[LAT-2:0], head.hit};
            tb_reg[0] <= head.base;
            for (int k = 1; k < LAT; k++)
                tb_reg[k] <= tb_reg[k-1];

            // drop every field to zero on a miss
            hit_reg  <= th_reg[LAT-1];
            dist_reg <= th_reg[LAT-1] ? 31'(sat_ratio(q_t, n_t, o_t)) : '0;
            ba_reg   <= th_reg[LAT-1] ? sat_ratio(q_a, n_a, o_a) : '0;
            bb_reg   <= th_reg[LAT-1] ? sat_ratio(q_b, n_b, o_b) : '0;
            bc_reg   <= th_reg[LAT-1] ? sat_ratio(q_c, n_c, o_c) : '0;
            px_reg   <= th_reg[LAT-1] ? sat_point(q_x, n_x, o_x, tb_reg[LAT-1][0]) : '0;
            py_reg   <= th_reg[LAT-1] ? sat_point(q_y, n_y, o_y, tb_reg[LAT-1][1]) : '0;
            pz_reg   <= th_reg[LAT-1] ? sat_point(q_z, n_z, o_z, tb_reg[LAT-1][2]) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign dist_t    = dist_reg;
    assign bary_a    = ba_reg;
    assign bary_b    = bb_reg;
    assign bary_c    = bc_reg;
    assign hit_x     = px_reg;
    assign hit_y     = py_reg;
    assign hit_z     = pz_reg;

endmodule

[sim/ray_triangle_intersect_tb.sv]
`timescale 1ns / 1ps
module ray_triangle_intersect_tb;
    import rti_pkg::*;

    typedef struct {
        logic [FIELD_W-1:0] origin;
        logic [FIELD_W-1:0] dir;
        logic [FIELD_W-1:0] va;
        logic [FIELD_W-1:0] vb;
        logic [FIELD_W-1:0] vc;
        logic               plane;
    } ray_tri_t;

    typedef struct {
        logic               hit;
        logic [30:0]        t_fx;
        logic signed [31:0] ba;
        logic signed [31:0] bb;
        logic signed [31:0] bc;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
    } hit_rec_t;

    typedef logic signed [127:0] wide_t;

    localparam int    GAP_MAX    = 18;
    localparam int    STALL_MAX  = 18;
    localparam int    WATCHDOG   = 4000;
    localparam int    DRAIN      = 60;
    localparam int    NUM_RANDOM = 750;
    localparam wide_t PT_MAX     = 32767;
    localparam wide_t PT_MIN     = -32768;
    localparam wide_t DELTA_LIM  = wide_t'(1) <<< 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [FIELD_W-1:0] ray_origin = '0;
    logic [FIELD_W-1:0] ray_dir = '0;
    logic [FIELD_W-1:0] vert_a = '0;
    logic [FIELD_W-1:0] vert_b = '0;
    logic [FIELD_W-1:0] vert_c = '0;
    logic plane_mode = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic [30:0] dist_t;
    logic signed [31:0] bary_a, bary_b, bary_c;
    logic signed [CW-1:0] hit_x, hit_y, hit_z;

    ray_tri_t pending_rays[$];
    hit_rec_t expected_hits[$];
    int       errors = 0;
    int       rays_sent = 0;
    int       results_seen = 0;
    int       hits_seen = 0;
    int       pause_at = -1;
    int       gap_left = 0;
    int       stall_left = 0;
    int       quiet_cycles = 0;
    bit       burst_mode = 1'b0;

    ray_triangle_intersect dut (.*);

    always #5 clk = ~clk;

    // Pack three signed coordinates z:y:x, x in the low bits.
    function automatic logic [FIELD_W-1:0] pack3(int x, int y, int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic wide_t coord_of(logic [FIELD_W-1:0] f, int k);
        return wide_t'($signed(f[16*k +: 16]));
    endfunction

    // Floor division for a positive divisor, clamped to [lo, hi].
    function automatic wide_t floor_div_sat(wide_t num, wide_t den, wide_t lo, wide_t hi);
        wide_t q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return q;
    endfunction

    function automatic hit_rec_t trace_ray(ray_tri_t r);
        wide_t    a[3], ab[3], ac[3], qp[3], ap[3], n[3], e[3];
        wide_t    d, t, v, w, p;
        hit_rec_t res;
        res = '{default: '0};
        for (int i = 0; i < 3; i++)
        begin
            a[i]  = coord_of(r.va, i);
            qp[i] = -coord_of(r.dir, i);
            ab[i] = coord_of(r.vb, i) - a[i];
            ac[i] = coord_of(r.vc, i) - a[i];
            ap[i] = coord_of(r.origin, i) - a[i];
        end
        n[0] = ab[1] * ac[2] - ab[2] * ac[1];
        n[1] = ab[2] * ac[0] - ab[0] * ac[2];
        n[2] = ab[0] * ac[1] - ab[1] * ac[0];
        d = qp[0] * n[0] + qp[1] * n[1] + qp[2] * n[2];
        if (d <= 0)
            return res;
        t = ap[0] * n[0] + ap[1] * n[1] + ap[2] * n[2];
        if (t < 0)
            return res;
        e[0] = qp[1] * ap[2] - qp[2] * ap[1];
        e[1] = qp[2] * ap[0] - qp[0] * ap[2];
        e[2] = qp[0] * ap[1] - qp[1] * ap[0];
        v = ac[0] * e[0] + ac[1] * e[1] + ac[2] * e[2];
        w = -(ab[0] * e[0] + ab[1] * e[1] + ab[2] * e[2]);
        if (!r.plane && (v < 0 || v > d || w < 0 || v + w > d))
            return res;
        res.hit  = 1'b1;
        res.t_fx = 31'(floor_div_sat(t <<< 16, d, 0, 32'h7FFF_FFFF));
        res.ba   = 32'(floor_div_sat((d - v - w) <<< 16, d, -(wide_t'(1) <<< 31),
                                     (wide_t'(1) <<< 31) - 1));
        res.bb   = 32'(floor_div_sat(v <<< 16, d, -(wide_t'(1) <<< 31),
                                     (wide_t'(1) <<< 31) - 1));
        res.bc   = 32'(floor_div_sat(w <<< 16, d, -(wide_t'(1) <<< 31),
                                     (wide_t'(1) <<< 31) - 1));
        for (int i = 0; i < 3; i++)
        begin
            p = a[i] + floor_div_sat(v * ab[i] + w * ac[i], d, -DELTA_LIM, DELTA_LIM);
            if (p > PT_MAX) p = PT_MAX;
            if (p < PT_MIN) p = PT_MIN;
            if (i == 0) res.px = 16'(p);
            else if (i == 1) res.py = 16'(p);
            else res.pz = 16'(p);
        end
        return res;
    endfunction

    function automatic ray_tri_t make_ray(logic [FIELD_W-1:0] o, logic [FIELD_W-1:0] dr,
                                          logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                          logic [FIELD_W-1:0] c, logic pl);
        ray_tri_t r;
        r.origin = o; r.dir = dr; r.va = a; r.vb = b; r.vc = c; r.plane = pl;
        return r;
    endfunction

    function automatic int clamp16(int x);
        return (x > 32767) ? 32767 : ((x < -32768) ? -32768 : x);
    endfunction

    function automatic int rand_coord(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // Aim a ray from a random origin at a random point near the triangle.
    function automatic ray_tri_t aimed_ray();
        int       span, pos[3][3], o[3], dr[3], wb, wc;
        ray_tri_t r;
        span = ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(64, 3000);
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                pos[k][i] = rand_coord(span);
        wb = $urandom_range(0, 256);
        wc = $urandom_range(0, 256 - wb);
        for (int i = 0; i < 3; i++)
        begin
            o[i]  = rand_coord(span);
            dr[i] = clamp16((pos[0][i] * (256 - wb - wc) + pos[1][i] * wb + pos[2][i] * wc)
                            / 256 - o[i] + rand_coord(8));
            if ($urandom_range(0, 3) == 0)
                dr[i] = clamp16(dr[i] / 64);
        end
        r.origin = pack3(o[0], o[1], o[2]);
        r.dir    = pack3(dr[0], dr[1], dr[2]);
        r.va     = pack3(pos[0][0], pos[0][1], pos[0][2]);
        r.vb     = pack3(pos[1][0], pos[1][1], pos[1][2]);
        r.vc     = pack3(pos[2][0], pos[2][1], pos[2][2]);
        r.plane  = ($urandom_range(0, 4) == 0);
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] rand48();
        return FIELD_W'({$urandom(), $urandom()});
    endfunction

    // Driver: present one beat at a time, insert a random gap before each outside
    // burst mode, and hold at the pressure point until every result is back.
    always @(posedge clk)
    begin
        logic     send_next;
        ray_tri_t r;
        if (rst_n)
        begin
            send_next = 1'b0;
            if (in_valid && !in_stall)
            begin
                expected_hits.push_back(trace_ray(make_ray(ray_origin, ray_dir, vert_a,
                                                           vert_b, vert_c, plane_mode)));
                rays_sent++;
                if (rays_sent % 64 == 0)
                    burst_mode = ~burst_mode;
                gap_left = burst_mode ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_rays.size() > 0 &&
                         !(rays_sent == pause_at && expected_hits.size() > 0))
                    send_next = 1'b1;
                if (send_next)
                begin
                    r = pending_rays.pop_front();
                    ray_origin <= r.origin;
                    ray_dir    <= r.dir;
                    vert_a     <= r.va;
                    vert_b     <= r.vb;
                    vert_c     <= r.vc;
                    plane_mode <= r.plane;
                end
                in_valid <= send_next;
            end
        end
    end

    // Monitor: check each result beat against the oldest expectation,
    // then draw how long to stall before taking the next one.
    always @(posedge clk)
    begin
        hit_rec_t exp_rec;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_hits.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat hit=%0d", $realtime, hit);
                end
                else
                begin
                    exp_rec = expected_hits.pop_front();
                    if (exp_rec.hit) hits_seen++;
                    if (hit !== exp_rec.hit || dist_t !== exp_rec.t_fx ||
                        bary_a !== exp_rec.ba || bary_b !== exp_rec.bb ||
                        bary_c !== exp_rec.bc || hit_x !== exp_rec.px ||
                        hit_y !== exp_rec.py || hit_z !== exp_rec.pz)
                    begin
                        errors++;
                        $display("%0t: mismatch expected hit=%0d t=%h a=%h b=%h c=%h p=%h,%h,%h",
                                 $realtime, exp_rec.hit, exp_rec.t_fx, exp_rec.ba,
                                 exp_rec.bb, exp_rec.bc, exp_rec.px, exp_rec.py, exp_rec.pz);
                        $display("%0t:          actual hit=%0d t=%h a=%h b=%h c=%h p=%h,%h,%h",
                                 $realtime, hit, dist_t, bary_a, bary_b, bary_c,
                                 hit_x, hit_y, hit_z);
                    end
                end
                stall_left = burst_mode ? 0 : $urandom_range(0, STALL_MAX);
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Watchdog: drop the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $realtime, expected_hits.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int q, z;
        q = 256;
        z = 0;
        // Directed beats: all-zero and all-ones fields, then a unit triangle in the z=0 plane, normal along +z.
        pending_rays.push_back(make_ray('0, '0, '0, '0, '0, 1'b0));
        pending_rays.push_back(make_ray('1, '1, '1, '1, '1, 1'b1));
        pending_rays.push_back(make_ray(pack3(64, 64, q), pack3(z, z, -q),
                                        '0, pack3(q, z, z), pack3(z, q, z), 1'b0));
        pending_rays.push_back(make_ray(pack3(z, z, q), pack3(z, z, -q),
                                        '0, pack3(q, z, z), pack3(z, q, z), 1'b0));
        pending_rays.push_back(make_ray(pack3(128, 128, q), pack3(z, z, -q),
                                        '0, pack3(q, z, z), pack3(z, q, z), 1'b0));
        // Outside the triangle: miss, then hit in plane mode.
        pending_rays.push_back(make_ray(pack3(1024, -900, q), pack3(z, z, -q),
                                        '0, pack3(q, z, z), pack3(z, q, z), 1'b0));
        pending_rays.push_back(make_ray(pack3(1024, -900, q), pack3(z, z, -q),
                                        '0, pack3(q, z, z), pack3(z, q, z), 1'b1));
        // Parallel, back-facing, behind the origin, degenerate.
        pending_rays.push_back(make_ray(pack3(64, 64, q), pack3(q, z, z),
                                        '0, pack3(q, z, z), pack3(z, q, z), 1'b0));
        pending_rays.push_back(make_ray(pack3(64, 64, -q), pack3(z, z, q),
                                        '0, pack3(q, z, z), pack3(z, q, z), 1'b0));
        pending_rays.push_back(make_ray(pack3(64, 64, -q), pack3(z, z, -q),
                                        '0, pack3(q, z, z), pack3(z, q, z), 1'b0));
        pending_rays.push_back(make_ray(pack3(64, 64, q), pack3(z, z, -q),
                                        '0, pack3(q, z, z), pack3(q, z, z), 1'b1));
        // Saturation: huge t, far plane-mode point, full-scale coordinates.
        pending_rays.push_back(make_ray(pack3(z, z, 32767), pack3(z, z, -1),
                                        '0, pack3(32767, z, z), pack3(z, 32767, z), 1'b0));
        pending_rays.push_back(make_ray(pack3(32767, -32768, q), pack3(1, -1, -1),
                                        '0, pack3(1, z, z), pack3(z, 1, z), 1'b1));
        pending_rays.push_back(make_ray(pack3(-32768, -32768, 32767),
                                        pack3(32767, 32767, -32768),
                                        pack3(-32768, -32768, -32768),
                                        pack3(32767, -32768, -32768),
                                        pack3(-32768, 32767, -32768), 1'b1));
        // Negative coordinates: sign bits set in the x and y slots.
        pending_rays.push_back(make_ray(pack3(-1, -1, q), pack3(z, z, -q),
                                        pack3(-q, -q, z), pack3(q, -q, z),
                                        pack3(-q, q, z), 1'b0));
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                pending_rays.push_back(make_ray(rand48(), rand48(), rand48(), rand48(),
                                                rand48(), 1'($urandom_range(0, 1))));
            else
                pending_rays.push_back(aimed_ray());
        end
        pause_at = 300;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_rays.size() == 0 && !in_valid && expected_hits.size() == 0);
        repeat (DRAIN) @(posedge clk);
        $display("Sent %0d ray/triangle beats, %0d results checked, %0d hits.",
                 rays_sent, results_seen, hits_seen);
        $display("Covered misses, plane mode, saturation and random back-pressure.");
        if (errors == 0 && expected_hits.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
